// ===== sv/clpg_pkg.sv =====
// shared types, constants and register codes for the clipped line pixel generator
package clpg_pkg;

    // coordinate width of the endpoint fields
    localparam int COORD_BITS = 16;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int COUNT_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 1;

    // fixed field widths
    localparam int CLIP_BITS  = 15;
    localparam int PITCH_BITS = 16;
    localparam int COLOR_BITS = 8;
    localparam int ADDR_BITS  = 31;
    localparam int CFG_DATA_BITS  = PITCH_BITS;
    localparam int CFG_INDEX_BITS = 2;

    // compare width for clipping, wide enough for either side
    localparam int CMP_BITS = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS;

    // stream packing
    localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = ADDR_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;

    // item kind carried on tuser
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LINE_PITCH  = 2'd0,
        CFG_CLIP_WIDTH  = 2'd1,
        CFG_CLIP_HEIGHT = 2'd2
    } cfg_index_t;

    // one accepted input transaction
    typedef struct packed {
        op_t                   op;
        coord_t                x_start;
        coord_t                y_start;
        coord_t                x_end;
        coord_t                y_end;
        logic [COLOR_BITS-1:0] color;
    } item_t;

    // one pixel between the stepper and the address stage
    typedef struct packed {
        logic [CLIP_BITS-1:0]  x;
        logic [CLIP_BITS-1:0]  y;
        logic [COLOR_BITS-1:0] color;
        logic                  in_bounds;
        logic                  last;
    } pixel_t;

    // one finished result
    typedef struct packed {
        logic [ADDR_BITS-1:0]  addr;
        logic [COLOR_BITS-1:0] color;
        logic                  in_bounds;
        logic                  last;
    } result_t;

endpackage

// ===== sv/clpg_stepper.sv =====
// line state and per-pixel bresenham step, feeding the pixel register
module clpg_stepper import clpg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_take,
    input  logic [CLIP_BITS-1:0] clip_width,
    input  logic [CLIP_BITS-1:0] clip_height,
    output logic                 pix_valid,
    output pixel_t               pix,
    input  logic                 pix_take
);

    // line state
    coord_t                cur_x_reg, cur_x_next;
    coord_t                cur_y_reg, cur_y_next;
    logic [ERR_BITS-1:0]   err_reg, err_next;
    logic [COORD_BITS-1:0] major_reg, major_next;
    logic [COORD_BITS-1:0] minor_reg, minor_next;
    logic                  x_neg_reg, x_neg_next;
    logic                  y_neg_reg, y_neg_next;
    logic                  major_y_reg, major_y_next;
    logic [COUNT_BITS-1:0] left_reg, left_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic                  active_reg, active_next;

    logic                  pix_valid_reg, pix_valid_next;
    pixel_t                pix_reg, pix_next;

    // load arithmetic
    logic [DELTA_BITS-1:0] dx, dy, dx_abs, dy_abs;
    logic [COORD_BITS-1:0] ax, ay;
    logic                  load_major_y;

    // advance arithmetic
    logic                  emit;
    logic                  last;
    logic                  in_clip;
    logic [ERR_BITS-1:0]   err_sum;
    logic                  minor_step;
    coord_t                x_stepped, y_stepped;

    // transaction moves on when the pixel register has room
    assign item_take = item_valid && (!pix_valid_reg || pix_take);
    assign emit      = item_take && (item.op == OP_ADVANCE) && active_reg;

    // endpoint deltas and magnitudes
    always_comb begin
        dx = {item.x_end[COORD_BITS-1], item.x_end}
           - {item.x_start[COORD_BITS-1], item.x_start};
        dy = {item.y_end[COORD_BITS-1], item.y_end}
           - {item.y_start[COORD_BITS-1], item.y_start};
        dx_abs = dx[DELTA_BITS-1] ? (~dx + DELTA_BITS'(1)) : dx;
        dy_abs = dy[DELTA_BITS-1] ? (~dy + DELTA_BITS'(1)) : dy;
        ax = dx_abs[COORD_BITS-1:0];
        ay = dy_abs[COORD_BITS-1:0];
        load_major_y = (ay >= ax);
    end

    // clipping and stepping from the current position
    always_comb begin
        in_clip = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1]
               && (CMP_BITS'(cur_x_reg) < CMP_BITS'(clip_width))
               && (CMP_BITS'(cur_y_reg) < CMP_BITS'(clip_height));
        last       = (left_reg <= COUNT_BITS'(1));
        err_sum    = err_reg + ERR_BITS'(minor_reg);
        minor_step = (err_sum >= ERR_BITS'(major_reg));
        x_stepped  = x_neg_reg ? (cur_x_reg - COORD_BITS'(1)) : (cur_x_reg + COORD_BITS'(1));
        y_stepped  = y_neg_reg ? (cur_y_reg - COORD_BITS'(1)) : (cur_y_reg + COORD_BITS'(1));
    end

    // next state
    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        err_next     = err_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        major_y_next = major_y_reg;
        left_next    = left_reg;
        color_next   = color_reg;
        active_next  = active_reg;

        pix_next.x         = CLIP_BITS'(cur_x_reg);
        pix_next.y         = CLIP_BITS'(cur_y_reg);
        pix_next.color     = color_reg;
        pix_next.in_bounds = in_clip;
        pix_next.last      = last;

        if (item_take && (item.op == OP_LOAD)) begin
            cur_x_next   = item.x_start;
            cur_y_next   = item.y_start;
            x_neg_next   = dx[DELTA_BITS-1] || (dx == '0);
            y_neg_next   = dy[DELTA_BITS-1] || (dy == '0);
            major_y_next = load_major_y;
            major_next   = load_major_y ? ay : ax;
            minor_next   = load_major_y ? ax : ay;
            err_next     = '0;
            left_next    = COUNT_BITS'(load_major_y ? ay : ax) + COUNT_BITS'(1);
            color_next   = item.color;
            active_next  = 1'b1;
        end else if (emit) begin
            if (last) begin
                left_next   = '0;
                active_next = 1'b0;
            end else begin
                left_next = left_reg - COUNT_BITS'(1);
                if (major_y_reg) begin
                    cur_y_next = y_stepped;
                end else begin
                    cur_x_next = x_stepped;
                end
                if (minor_step) begin
                    err_next = err_sum - ERR_BITS'(major_reg);
                    if (major_y_reg) begin
                        cur_x_next = x_stepped;
                    end else begin
                        cur_y_next = y_stepped;
                    end
                end else begin
                    err_next = err_sum;
                end
            end
        end

        // pixel register handshake
        if (emit) begin
            pix_valid_next = 1'b1;
        end else if (pix_take) begin
            pix_valid_next = 1'b0;
        end else begin
            pix_valid_next = pix_valid_reg;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            major_y_reg   <= 1'b0;
            left_reg      <= '0;
            color_reg     <= '0;
            active_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
        end else begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            err_reg       <= err_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            x_neg_reg     <= x_neg_next;
            y_neg_reg     <= y_neg_next;
            major_y_reg   <= major_y_next;
            left_reg      <= left_next;
            color_reg     <= color_next;
            active_reg    <= active_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // pixel payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            pix_reg <= pix_next;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

// ===== sv/clpg_addr.sv =====
// buffer address stage: y times pitch plus x into the output register
module clpg_addr import clpg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [PITCH_BITS-1:0] line_pitch,
    input  logic                  pix_valid,
    input  pixel_t                pix,
    output logic                  pix_take,
    output logic                  out_valid,
    output result_t               out_data,
    input  logic                  out_ready
);

    logic                            out_valid_reg, out_valid_next;
    result_t                         out_reg, out_next;
    logic [CLIP_BITS+PITCH_BITS-1:0] row_offset;

    // output register takes a pixel when empty or being drained
    assign pix_take = pix_valid && (!out_valid_reg || out_ready);

    // address, zero for clipped pixels
    always_comb begin
        row_offset         = pix.y * line_pitch;
        out_next.addr      = pix.in_bounds
                           ? (ADDR_BITS'(row_offset) + ADDR_BITS'(pix.x))
                           : '0;
        out_next.color     = pix.color;
        out_next.in_bounds = pix.in_bounds;
        out_next.last      = pix.last;

        if (pix_take) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_take) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/clipped_line_pixel_generator_top.sv =====
// Clipped line pixel generator: Bresenham stepping with clipping and buffer addressing.
// An advance transaction passes from the input register into the stepper's pixel register,
// then through the address multiply into the output register that drives m_.
// Throughput: one transaction per cycle, loads and advances alike, unless m_tready stalls;
// set by the stepper loop. Reset: synchronous active-low aresetn clears the configuration
// registers, the line state and all valid flags; no line is active afterwards.
module clipped_line_pixel_generator_top import clpg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // x_start, y_start, x_end, y_end, line_color
    input  logic [IN_DATA_BITS-1:0]   s_tdata,
    // op
    input  logic                      s_tuser,
    // pixel stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pixel_address, pixel_color, zero padding
    output logic [OUT_DATA_BITS-1:0]  m_tdata,
    // in_bounds
    output logic                      m_tuser,
    output logic                      m_tlast
);

    logic [PITCH_BITS-1:0] pitch_reg;
    logic [CLIP_BITS-1:0]  width_reg;
    logic [CLIP_BITS-1:0]  height_reg;

    logic    in_valid_reg, in_valid_next;
    item_t   in_reg, in_next;
    logic    item_take;
    logic    pix_valid;
    pixel_t  pix;
    logic    pix_take;
    logic    out_valid;
    result_t out_data;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg  <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LINE_PITCH:  pitch_reg  <= cfg_wdata[PITCH_BITS-1:0];
                CFG_CLIP_WIDTH:  width_reg  <= cfg_wdata[CLIP_BITS-1:0];
                CFG_CLIP_HEIGHT: height_reg <= cfg_wdata[CLIP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign s_tready = !in_valid_reg || item_take;

    always_comb begin
        in_next.op      = op_t'(s_tuser);
        in_next.x_start = s_tdata[0 +: COORD_BITS];
        in_next.y_start = s_tdata[COORD_BITS +: COORD_BITS];
        in_next.x_end   = s_tdata[2*COORD_BITS +: COORD_BITS];
        in_next.y_end   = s_tdata[3*COORD_BITS +: COORD_BITS];
        in_next.color   = s_tdata[4*COORD_BITS +: COLOR_BITS];
        in_valid_next   = s_tready ? s_tvalid : in_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= in_next;
        end
    end

    clpg_stepper u_stepper (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (in_valid_reg),
        .item        (in_reg),
        .item_take   (item_take),
        .clip_width  (width_reg),
        .clip_height (height_reg),
        .pix_valid   (pix_valid),
        .pix         (pix),
        .pix_take    (pix_take)
    );

    clpg_addr u_addr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_pitch (pitch_reg),
        .pix_valid  (pix_valid),
        .pix        (pix),
        .pix_take   (pix_take),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .out_ready  (m_tready)
    );

    // output stream
    assign m_tvalid = out_valid;
    assign m_tdata  = {OUT_PAD_BITS'(0), out_data.color, out_data.addr};
    assign m_tuser  = out_data.in_bounds;
    assign m_tlast  = out_data.last;

    // clipped pixels carry a zero address
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[ADDR_BITS-1:0] == '0))
        else $error("clipped pixel with nonzero address");

    // a waiting pixel is not lost while the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pix_valid && m_tvalid && !m_tready) |=> pix_valid)
        else $error("pixel dropped under output stall");

    // nothing leaves the block straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !pix_valid))
        else $error("valid raised out of reset");

endmodule
